// ----- design/length_crc_frame_checker_macros.svh -----
// assertion macros shared by the frame checker rtl
`ifndef LENGTH_CRC_FRAME_CHECKER_MACROS_SVH
`define LENGTH_CRC_FRAME_CHECKER_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define LCFC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lcfc assertion failed");

// next-cycle implication, disabled while reset is asserted
`define LCFC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lcfc assertion failed");

`endif

// ----- design/lcfc_pkg.sv -----
// types and constants of the length/crc frame checker
package lcfc_pkg;

  typedef enum logic [2:0] {
    ST_LEN,
    ST_NLEN,
    ST_BODY,
    ST_CSUM,
    ST_HALT
  } state_t;

  typedef enum logic [2:0] {
    ROLE_LEN  = 3'd0,
    ROLE_NAME = 3'd1,
    ROLE_TERM = 3'd2,
    ROLE_BODY = 3'd3,
    ROLE_CSUM = 3'd4,
    ROLE_DROP = 3'd5
  } role_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_BAD_LEN  = 2'd1,
    STAT_BAD_CRC  = 2'd2,
    STAT_BAD_NAME = 2'd3
  } status_t;

  typedef struct packed {
    role_t   role;
    logic    frame_end;
    status_t status;
  } result_t;

  localparam int unsigned CFG_W = 31;

  localparam logic CFG_MIN_LENGTH = 1'b0;
  localparam logic CFG_MAX_LENGTH = 1'b1;

  localparam logic [CFG_W-1:0] MIN_LENGTH_RST = 31'd10;
  localparam logic [CFG_W-1:0] MAX_LENGTH_RST = 31'd67108864;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFE;

  // smallest frame: name length field plus checksum
  localparam logic [CFG_W-1:0] LEN_FLOOR = 31'd8;
  localparam logic [CFG_W-1:0] NAME_FLOOR = 31'd2;

endpackage

// ----- design/lcfc_crc8.sv -----
// reflected crc-32 update by one byte
module lcfc_crc8 (
  input  logic [31:0] crc_in,
  input  logic [7:0]  data_in,
  output logic [31:0] crc_out
);

  always_comb begin
    logic [31:0] c;
    c = crc_in ^ {24'd0, data_in};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ lcfc_pkg::CRC_POLY) : (c >> 1);
    end
    crc_out = c;
  end

endmodule

// ----- design/lcfc_frame_fsm.sv -----
// frame parser: field tracking, checks and per-beat result
module lcfc_frame_fsm (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      step,
  input  logic [7:0]                data_byte,
  input  logic [lcfc_pkg::CFG_W-1:0] min_length,
  input  logic [lcfc_pkg::CFG_W-1:0] max_length,
  output lcfc_pkg::result_t         res
);

  lcfc_pkg::state_t st_r, st_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [23:0] len_r, len_nxt;
  logic [23:0] nlen_r, nlen_nxt;
  logic [23:0] rx_r, rx_nxt;
  logic [lcfc_pkg::CFG_W-1:0] lim_r, lim_nxt;
  logic [lcfc_pkg::CFG_W-1:0] body_rem_r, body_rem_nxt;
  logic [lcfc_pkg::CFG_W-1:0] nrem_r, nrem_nxt;
  logic name_ok_r, name_ok_nxt;

  logic [31:0] crc_upd;
  logic [31:0] len_full, nlen_full, csum_full;
  logic        len_bad, nlen_ok, crc_bad;

  lcfc_crc8 u_crc (
    .crc_in  (crc_r),
    .data_in (data_byte),
    .crc_out (crc_upd)
  );

  assign len_full  = {len_r, data_byte};
  assign nlen_full = {nlen_r, data_byte};
  assign csum_full = {rx_r, data_byte};

  assign len_bad = len_full[31]
                || (len_full[30:0] < lcfc_pkg::LEN_FLOOR)
                || (len_full[30:0] < min_length)
                || (len_full[30:0] > max_length);

  assign nlen_ok = !nlen_full[31]
                && (nlen_full[30:0] >= lcfc_pkg::NAME_FLOOR)
                && (nlen_full[30:0] <= lim_r);

  assign crc_bad = (~crc_r) != csum_full;

  always_comb begin
    st_nxt       = st_r;
    cnt_nxt      = cnt_r;
    crc_nxt      = crc_r;
    len_nxt      = len_r;
    nlen_nxt     = nlen_r;
    rx_nxt       = rx_r;
    lim_nxt      = lim_r;
    body_rem_nxt = body_rem_r;
    nrem_nxt     = nrem_r;
    name_ok_nxt  = name_ok_r;
    res.role      = lcfc_pkg::ROLE_LEN;
    res.frame_end = 1'b0;
    res.status    = lcfc_pkg::STAT_OK;
    unique case (st_r)
      lcfc_pkg::ST_LEN: begin
        len_nxt = len_full[23:0];
        cnt_nxt = cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          if (len_bad) begin
            res.frame_end = 1'b1;
            res.status    = lcfc_pkg::STAT_BAD_LEN;
            st_nxt        = lcfc_pkg::ST_HALT;
          end else begin
            lim_nxt      = len_full[30:0] - lcfc_pkg::LEN_FLOOR;
            body_rem_nxt = len_full[30:0] - lcfc_pkg::LEN_FLOOR;
            st_nxt       = lcfc_pkg::ST_NLEN;
          end
        end
      end
      lcfc_pkg::ST_NLEN: begin
        crc_nxt  = crc_upd;
        nlen_nxt = nlen_full[23:0];
        cnt_nxt  = cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          name_ok_nxt = nlen_ok;
          nrem_nxt    = nlen_full[30:0];
          st_nxt      = (body_rem_r == '0) ? lcfc_pkg::ST_CSUM : lcfc_pkg::ST_BODY;
        end
      end
      lcfc_pkg::ST_BODY: begin
        crc_nxt = crc_upd;
        if (!name_ok_r) begin
          res.role = lcfc_pkg::ROLE_BODY;
        end else if (nrem_r == '0) begin
          res.role = lcfc_pkg::ROLE_BODY;
        end else if (nrem_r == {{(lcfc_pkg::CFG_W-1){1'b0}}, 1'b1}) begin
          res.role = lcfc_pkg::ROLE_TERM;
        end else begin
          res.role = lcfc_pkg::ROLE_NAME;
        end
        if (nrem_r != '0) begin
          nrem_nxt = nrem_r - {{(lcfc_pkg::CFG_W-1){1'b0}}, 1'b1};
        end
        body_rem_nxt = body_rem_r - {{(lcfc_pkg::CFG_W-1){1'b0}}, 1'b1};
        if (body_rem_r == {{(lcfc_pkg::CFG_W-1){1'b0}}, 1'b1}) begin
          st_nxt = lcfc_pkg::ST_CSUM;
        end
      end
      lcfc_pkg::ST_CSUM: begin
        res.role = lcfc_pkg::ROLE_CSUM;
        rx_nxt   = csum_full[23:0];
        cnt_nxt  = cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          res.frame_end = 1'b1;
          if (crc_bad) begin
            res.status = lcfc_pkg::STAT_BAD_CRC;
            st_nxt     = lcfc_pkg::ST_HALT;
          end else if (!name_ok_r) begin
            res.status = lcfc_pkg::STAT_BAD_NAME;
            st_nxt     = lcfc_pkg::ST_HALT;
          end else begin
            crc_nxt = lcfc_pkg::CRC_INIT;
            st_nxt  = lcfc_pkg::ST_LEN;
          end
        end
      end
      lcfc_pkg::ST_HALT: begin
        res.role = lcfc_pkg::ROLE_DROP;
      end
      default: begin
        res.role = lcfc_pkg::ROLE_DROP;
        st_nxt   = lcfc_pkg::ST_HALT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= lcfc_pkg::ST_LEN;
      cnt_r <= 2'd0;
      crc_r <= lcfc_pkg::CRC_INIT;
    end else if (step) begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
      crc_r <= crc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      len_r      <= len_nxt;
      nlen_r     <= nlen_nxt;
      rx_r       <= rx_nxt;
      lim_r      <= lim_nxt;
      body_rem_r <= body_rem_nxt;
      nrem_r     <= nrem_nxt;
      name_ok_r  <= name_ok_nxt;
    end
  end

endmodule

// ----- design/length_crc_frame_checker.sv -----
// Length-prefixed frame checker with CRC-32. Takes one stream byte per beat; each frame is a
// 4-byte big-endian length L, then L bytes: 4-byte name length N, type name (last byte is the
// terminator), body and 4-byte big-endian checksum. The checksum is the reflected CRC-32 started
// from running value 0xFFFFFFFE over every byte between the length field and the checksum. Every byte
// comes back out with a role tag in out_tuser; out_tlast marks a frame's last byte (status ok,
// checksum error or bad name length, checksum error first) or a length outside
// [min_length, max_length] or below 8, flagged on the fourth length byte. After any error the
// block tags all further bytes as dropped until reset. Throughput is one byte per clock while the
// result side does not stall; each byte passes an input register, the byte-wide CRC update and
// field counters, then the result register. Configuration registers take effect for the next
// byte and must be written while no beat is in flight.
module length_crc_frame_checker (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_byte
  output logic [4:0]  out_tuser,  // [2:0] role, [4:3] status
  output logic        out_tlast,  // frame_end
  // configuration writes
  input  logic                       cfg_we,
  input  logic                       cfg_addr,
  input  logic [lcfc_pkg::CFG_W-1:0] cfg_wdata
);

  `include "length_crc_frame_checker_macros.svh"

  // config registers
  logic [lcfc_pkg::CFG_W-1:0] min_len_r;
  logic [lcfc_pkg::CFG_W-1:0] max_len_r;

  // input register
  logic       in_v_r;
  logic [7:0] in_byte_r;

  // result register
  logic              out_v_r;
  logic [7:0]        out_byte_r;
  lcfc_pkg::result_t out_res_r;

  lcfc_pkg::result_t res;
  logic in_fire, advance;

  // byte moves from input to result register when the result slot is free or draining
  assign advance   = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || advance;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_len_r <= lcfc_pkg::MIN_LENGTH_RST;
      max_len_r <= lcfc_pkg::MAX_LENGTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        lcfc_pkg::CFG_MIN_LENGTH: min_len_r <= cfg_wdata;
        lcfc_pkg::CFG_MAX_LENGTH: max_len_r <= cfg_wdata;
      endcase
    end
  end

  // input stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_fire) begin
      in_v_r <= 1'b1;
    end else if (advance) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_byte_r <= in_tdata;
    end
  end

  // parser state advances once per byte leaving the input register
  lcfc_frame_fsm u_fsm (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (advance),
    .data_byte  (in_byte_r),
    .min_length (min_len_r),
    .max_length (max_len_r),
    .res        (res)
  );

  // result stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte_r <= in_byte_r;
      out_res_r  <= res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = {out_res_r.status, out_res_r.role};
  assign out_tlast  = out_res_r.frame_end;

  // an error status only ever comes with the frame end flag
  `LCFC_ASSERT_IMP(a_status_needs_end, clk, rst_n, out_v_r && (out_res_r.status != lcfc_pkg::STAT_OK), out_res_r.frame_end)
  // dropped bytes never close a frame
  `LCFC_ASSERT_IMP(a_drop_no_end, clk, rst_n, out_v_r && (out_res_r.role == lcfc_pkg::ROLE_DROP), !out_res_r.frame_end)
  // an empty result slot always lets the input register drain
  `LCFC_ASSERT_IMP(a_drain_when_free, clk, rst_n, in_v_r && !out_v_r, advance && in_tready)
  // a byte held in the input register is not lost while the result side stalls
  `LCFC_ASSERT_NXT(a_hold_on_stall, clk, rst_n, in_v_r && !advance, in_v_r && $stable(in_byte_r))

endmodule

// ----- dv/tb_top.sv -----
// self-checking testbench for the length/crc frame checker
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // cycles with no beat on either side before the run is declared hung
  localparam int STALL_LIMIT = 2000;
  // length of the long receiver hold-off that fills the pipeline
  localparam int HOLD_CYCLES = 300;
  // cycles to let pass once the last expected beat has arrived
  localparam int TAIL_CYCLES = 8;

  // one result beat as the checker sees it
  typedef struct packed {
    logic [7:0]        data;
    lcfc_pkg::role_t   role;
    logic              last;
    lcfc_pkg::status_t status;
  } tag_beat_t;

  // which fault ends the run; the block halts for good after any of them
  typedef enum int {
    ERR_NEG_LEN,
    ERR_SHORT_LEN,
    ERR_BELOW_MIN,
    ERR_ABOVE_MAX,
    ERR_EMPTY_WINDOW,
    ERR_CHECKSUM,
    ERR_NAME_LEN
  } halt_cause_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_tvalid = 1'b0;
  logic                       in_tready;
  logic [7:0]                 in_tdata = 8'h00;
  logic                       out_tvalid;
  logic                       out_tready = 1'b0;
  logic [7:0]                 out_tdata;
  logic [4:0]                 out_tuser;
  logic                       out_tlast;
  logic                       cfg_we = 1'b0;
  logic                       cfg_addr = lcfc_pkg::CFG_MIN_LENGTH;
  logic [lcfc_pkg::CFG_W-1:0] cfg_wdata = '0;

  length_crc_frame_checker u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // expected tags of bytes accepted but not yet seen on the output
  tag_beat_t        pending_tags[$];
  int               mismatches = 0;
  int               bytes_in = 0;
  int               stall_cycles = 0;
  // random gaps on both sides while set
  bit               idle_en = 1'b0;
  bit               hold_request = 1'b0;
  int               quiet_left = 0;

  // frame tracker state, mirrors what the block keeps per frame
  logic [31:0]                fr_pos;
  logic [31:0]                fr_len;
  logic [31:0]                fr_nlen;
  logic [31:0]                fr_crc;
  logic [31:0]                fr_rx_csum;
  logic                       fr_halted;
  logic [lcfc_pkg::CFG_W-1:0] lim_min;
  logic [lcfc_pkg::CFG_W-1:0] lim_max;

  // reflected crc-32, one byte
  function automatic logic [31:0] crc32_byte(logic [31:0] c, logic [7:0] b);
    c = c ^ {24'd0, b};
    for (int i = 0; i < 8; i++)
      c = c[0] ? ((c >> 1) ^ lcfc_pkg::CRC_POLY) : (c >> 1);
    return c;
  endfunction

  function automatic void clear_frame_state();
    fr_pos     = '0;
    fr_len     = '0;
    fr_nlen    = '0;
    fr_crc     = lcfc_pkg::CRC_INIT;
    fr_rx_csum = '0;
  endfunction

  // name length must be positive, hold at least one char plus terminator,
  // and fit between the name length field and the checksum
  function automatic bit name_len_valid();
    return !fr_nlen[31] && fr_nlen >= 32'd2 && fr_nlen <= fr_len - 32'd8;
  endfunction

  // works out the tag of one accepted byte and advances the frame state
  function automatic tag_beat_t classify_byte(logic [7:0] b);
    tag_beat_t   t;
    logic [31:0] q;
    logic [31:0] term_at;
    t.data   = b;
    t.role   = lcfc_pkg::ROLE_LEN;
    t.last   = 1'b0;
    t.status = lcfc_pkg::STAT_OK;
    if (fr_halted) begin
      t.role = lcfc_pkg::ROLE_DROP;
      return t;
    end
    if (fr_pos < 32'd4) begin
      // big-endian frame length, judged on its fourth byte as a signed value
      fr_len = {fr_len[23:0], b};
      if (fr_pos == 32'd3 && (fr_len[31] || fr_len < 32'd8 ||
          fr_len < {1'b0, lim_min} || fr_len > {1'b0, lim_max})) begin
        t.last    = 1'b1;
        t.status  = lcfc_pkg::STAT_BAD_LEN;
        fr_halted = 1'b1;
      end
      fr_pos++;
    end else begin
      q = fr_pos - 32'd4;
      if (q < fr_len - 32'd4)
        fr_crc = crc32_byte(fr_crc, b);
      if (q < 32'd4) begin
        fr_nlen = {fr_nlen[23:0], b};
        fr_pos++;
      end else if (q < fr_len - 32'd4) begin
        // a name length out of range turns the whole payload into body
        if (name_len_valid()) begin
          term_at = 32'd3 + fr_nlen;
          if (q < term_at)
            t.role = lcfc_pkg::ROLE_NAME;
          else if (q == term_at)
            t.role = lcfc_pkg::ROLE_TERM;
          else
            t.role = lcfc_pkg::ROLE_BODY;
        end else begin
          t.role = lcfc_pkg::ROLE_BODY;
        end
        fr_pos++;
      end else begin
        fr_rx_csum = {fr_rx_csum[23:0], b};
        t.role     = lcfc_pkg::ROLE_CSUM;
        if (q == fr_len - 32'd1) begin
          // checksum error wins over a bad name length
          t.last = 1'b1;
          if (~fr_crc != fr_rx_csum) begin
            t.status  = lcfc_pkg::STAT_BAD_CRC;
            fr_halted = 1'b1;
          end else if (!name_len_valid()) begin
            t.status  = lcfc_pkg::STAT_BAD_NAME;
            fr_halted = 1'b1;
          end else begin
            clear_frame_state();
          end
        end else begin
          fr_pos++;
        end
      end
    end
    return t;
  endfunction

  // offers one byte, optionally after a random gap, and records its tag
  task automatic send_byte(input logic [7:0] b);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_tags.push_back(classify_byte(b));
    bytes_in++;
  endtask

  task automatic send_word(input logic [31:0] w);
    for (int i = 3; i >= 0; i--)
      send_byte(w[8*i +: 8]);
  endtask

  // whole frame: length, name length, payload, checksum (flipped bits make it bad)
  // fill < 0 gives random payload bytes, otherwise every payload byte is fill
  task automatic send_frame(input logic [31:0] len, input logic [31:0] nlen,
                            input logic [31:0] csum_flip, input int fill);
    logic [31:0] crc;
    logic [7:0]  b;
    int          payload;
    crc     = lcfc_pkg::CRC_INIT;
    payload = int'(len) - 8;
    send_word(len);
    for (int i = 3; i >= 0; i--) begin
      b   = nlen[8*i +: 8];
      crc = crc32_byte(crc, b);
      send_byte(b);
    end
    for (int i = 0; i < payload; i++) begin
      b   = (fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill);
      crc = crc32_byte(crc, b);
      send_byte(b);
    end
    send_word(~crc ^ csum_flip);
  endtask

  // well-formed frame inside the current limits, length capped for run time
  task automatic send_good_frame(input int cap);
    int lo;
    int hi;
    int len;
    int n;
    lo = (int'(lim_min) > 10) ? int'(lim_min) : 10;
    hi = (int'(lim_max) < cap) ? int'(lim_max) : cap;
    if (hi < lo)
      hi = lo;
    len = $urandom_range(hi, lo);
    case ($urandom_range(0, 3))
      0:       n = 2;
      1:       n = len - 8;
      default: n = $urandom_range(len - 8, 2);
    endcase
    send_frame(len, n, 32'd0, -1);
  endtask

  // stop offering and wait until every expected beat has come out
  task automatic drain();
    if (in_tvalid)
      in_tvalid <= 1'b0;
    while (pending_tags.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic addr, input logic [lcfc_pkg::CFG_W-1:0] value);
    drain();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (addr == lcfc_pkg::CFG_MIN_LENGTH)
      lim_min = value;
    else
      lim_max = value;
  endtask

  // reset limits: smallest frame, all-ones and all-zeros payloads
  task automatic test_directed_defaults();
    idle_en = 1'b0;
    send_frame(32'd10, 32'd2, 32'd0, 8'hFF);
    idle_en = 1'b1;
    send_frame(32'd11, 32'd2, 32'd0, 8'h00);
  endtask

  // widest legal window, name filling the payload and the shortest name
  task automatic test_limit_extremes();
    write_reg(lcfc_pkg::CFG_MIN_LENGTH, lcfc_pkg::LEN_FLOOR);
    write_reg(lcfc_pkg::CFG_MAX_LENGTH, 31'h7FFF_FFFF);
    send_frame(32'd10, 32'd2, 32'd0, -1);
    send_frame(32'd20, 32'd12, 32'd0, -1);
    send_frame(32'd40, 32'd2, 32'd0, -1);
    send_good_frame(24);
  endtask

  // min equal to max, every frame exactly on the bound
  task automatic test_exact_length_window();
    logic [lcfc_pkg::CFG_W-1:0] w;
    w = lcfc_pkg::CFG_W'($urandom_range(10, 32));
    write_reg(lcfc_pkg::CFG_MIN_LENGTH, w);
    write_reg(lcfc_pkg::CFG_MAX_LENGTH, w);
    repeat (3) send_good_frame(int'(w));
  endtask

  // random limits for some phases, mostly short frames and now and then a long one
  task automatic test_random_frames();
    int stop_at;
    int m;
    stop_at = bytes_in + 60;
    while (bytes_in < stop_at) begin
      if ($urandom_range(0, 1) == 0) begin
        m = $urandom_range(8, 40);
        write_reg(lcfc_pkg::CFG_MIN_LENGTH, lcfc_pkg::CFG_W'(m));
        if ($urandom_range(0, 3) == 0)
          write_reg(lcfc_pkg::CFG_MAX_LENGTH, 31'h7FFF_FFFF);
        else
          write_reg(lcfc_pkg::CFG_MAX_LENGTH,
                    lcfc_pkg::CFG_W'($urandom_range(80, (m > 10) ? m : 10)));
      end
      idle_en = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(2, 4))
        send_good_frame(($urandom_range(0, 9) == 0) ? 200 : 48);
    end
  endtask

  // receiver holds off for a long time while the sender keeps offering
  task automatic test_output_backpressure();
    drain();
    idle_en      = 1'b0;
    hold_request = 1'b1;
    write_reg(lcfc_pkg::CFG_MAX_LENGTH, 31'h7FFF_FFFF);
    send_good_frame(60);
    send_good_frame(60);
  endtask

  // last part, no gaps: a couple of good frames, one fault, then dropped bytes
  task automatic test_error_halt();
    halt_cause_t cause;
    int          len;
    logic [31:0] n;
    drain();
    idle_en = 1'b0;
    write_reg(lcfc_pkg::CFG_MIN_LENGTH, lcfc_pkg::MIN_LENGTH_RST);
    write_reg(lcfc_pkg::CFG_MAX_LENGTH, lcfc_pkg::MAX_LENGTH_RST);
    repeat (2) send_good_frame(40);
    cause = halt_cause_t'($urandom_range(0, 6));
    case (cause)
      ERR_NEG_LEN:
        send_word(32'h8000_0000 | $urandom);
      ERR_SHORT_LEN:
        send_word($urandom_range(0, 7));
      ERR_BELOW_MIN: begin
        write_reg(lcfc_pkg::CFG_MIN_LENGTH, 31'd100);
        send_word($urandom_range(8, 99));
      end
      ERR_ABOVE_MAX: begin
        write_reg(lcfc_pkg::CFG_MAX_LENGTH, 31'd50);
        send_word($urandom_range(32'h7FFF_FFFF, 51));
      end
      ERR_EMPTY_WINDOW: begin
        // min above max rejects everything
        write_reg(lcfc_pkg::CFG_MAX_LENGTH, lcfc_pkg::CFG_W'($urandom_range(8, 1000)));
        write_reg(lcfc_pkg::CFG_MIN_LENGTH, 31'h7FFF_FFFF);
        send_word($urandom_range(int'(lim_max), 8));
      end
      ERR_CHECKSUM: begin
        // half of the time the name length is bad too, checksum must win
        len = $urandom_range(10, 40);
        n   = ($urandom_range(0, 1) == 0) ? 32'($urandom_range(len - 8, 2)) : 32'd1;
        send_frame(len, n, 32'd1 << $urandom_range(0, 31), -1);
      end
      default: begin
        len = $urandom_range(10, 40);
        case ($urandom_range(0, 3))
          0:       n = 32'd0;
          1:       n = 32'd1;
          2:       n = len - 7 + $urandom_range(0, 20);
          default: n = 32'h8000_0000 | $urandom;
        endcase
        send_frame(len, n, 32'd0, -1);
      end
    endcase
    // everything after the fault is dropped
    repeat (20) send_byte(8'($urandom_range(0, 255)));
  endtask

  // result side: random stall bursts, plus the long hold on request
  always @(posedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      quiet_left   = HOLD_CYCLES;
    end
    if (quiet_left > 0) begin
      quiet_left--;
      out_tready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      quiet_left = $urandom_range(0, 16);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // compare each result beat with the oldest expected tag
  always @(posedge clk) begin : check_beats
    tag_beat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_tags.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: byte %02h tuser %02h last %0b",
                   out_tdata, out_tuser, out_tlast);
      end else begin
        want = pending_tags.pop_front();
        if (out_tdata !== want.data || out_tuser[2:0] !== want.role ||
            out_tlast !== want.last || out_tuser[4:3] !== want.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: byte %02h/%02h role %0d/%0d last %0b/%0b status %0d/%0d",
                     want.data, out_tdata, want.role, out_tuser[2:0],
                     want.last, out_tlast, want.status, out_tuser[4:3]);
        end
      end
    end
  end

  // hang detection: no beat on either side for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    fr_halted = 1'b0;
    lim_min   = lcfc_pkg::MIN_LENGTH_RST;
    lim_max   = lcfc_pkg::MAX_LENGTH_RST;
    clear_frame_state();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_defaults();
    test_limit_extremes();
    test_exact_length_window();
    test_random_frames();
    test_output_backpressure();
    test_error_halt();

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+design
design/lcfc_pkg.sv
design/lcfc_crc8.sv
design/lcfc_frame_fsm.sv
design/length_crc_frame_checker.sv
dv/tb_top.sv
